// ===== hw/rtl/cmpt_pkg.sv =====
// Shared types and constants for the complex magnitude/phase threshold detector.
package cmpt_pkg;

  // Angle accumulator width; pi is 2^31
  localparam int ZW = 34;
  localparam int TABLE_LEN = 24;
  localparam int GUARD_BITS = 8;
  localparam int GAIN_W = 30;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] PI_Z = 34'sd2147483648;
  localparam logic [15:0] THRESHOLD_RST = 16'd32768;
  localparam int MAG_SHIFT = 38;

  localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef struct packed {
    logic vld;
    logic zero;
    logic last;
  } cmpt_side_t;

endpackage

// ===== hw/rtl/complex_mag_phase_threshold_detect_core.sv =====
// Top level: input preparation, CORDIC cell chain and detector.
//
// Each complex sample goes through one preparation register, a row of
// min(CORDIC_STAGES, 24) CORDIC cells and three detector stages (gain
// multiply, rounding, threshold compare), all registered in that order;
// every stage holds one sample and the whole row moves on together, taking
// one sample per cycle while the result output is not stalled.
// A stalled result output freezes the row. The found flag and the
// first-crossing index are kept per buffer and clear after the sample
// marked by tlast; the index saturates at min(MAX_SAMPLES-1, 65535).
module complex_mag_phase_threshold_detect_core import cmpt_pkg::*; #(
  parameter int MAX_SAMPLES   = 65536,
  parameter int CORDIC_STAGES = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // sample_i [15:0], sample_q [31:16]
  input  logic [31:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // magnitude [15:0], phase [31:16], above [32], first_hit [33], found [34],
  // hit_index [50:35], zero fill [55:51]
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int IW = (SAMPLE_BITS > 16) ? 17 : SAMPLE_BITS;
  localparam int XW = IW + 12;

  logic                 en;
  logic [IW-1:0]        raw_i, raw_q;
  logic signed [XW-1:0] x_ext, y_ext, x_abs, y_abs;
  logic                 neg;

  cmpt_side_t           side_s [NS+1];
  logic signed [XW-1:0] x_s    [NS+1];
  logic signed [XW-1:0] y_s    [NS+1];
  logic signed [ZW-1:0] z_s    [NS+1];

  cmpt_side_t           side0_q;
  logic signed [XW-1:0] x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  if (SAMPLE_BITS > 16) begin : g_wide
    assign raw_i = {1'b0, s_axis_tdata_i[15:0]};
    assign raw_q = {1'b0, s_axis_tdata_i[31:16]};
  end else begin : g_narrow
    assign raw_i = s_axis_tdata_i[SAMPLE_BITS-1:0];
    assign raw_q = s_axis_tdata_i[16 +: SAMPLE_BITS];
  end

  assign neg   = raw_i[IW-1];
  assign x_ext = {{(XW-IW){raw_i[IW-1]}}, raw_i};
  assign y_ext = {{(XW-IW){raw_q[IW-1]}}, raw_q};
  assign x_abs = neg ? -x_ext : x_ext;
  assign y_abs = neg ? -y_ext : y_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side0_q <= '0;
    end else if (en) begin
      side0_q.vld  <= s_axis_tvalid_i;
      side0_q.zero <= (raw_i == '0) && (raw_q == '0);
      side0_q.last <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= x_abs <<< GUARD_BITS;
      y0_q <= y_abs <<< GUARD_BITS;
      z0_q <= neg ? PI_Z : '0;
    end
  end

  assign side_s[0] = side0_q;
  assign x_s[0]    = x0_q;
  assign y_s[0]    = y0_q;
  assign z_s[0]    = z0_q;

  for (genvar k = 0; k < NS; k++) begin : g_cell
    cmpt_cordic_cell #(
      .XW (XW),
      .K  (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .side_i (side_s[k]),
      .x_i    (x_s[k]),
      .y_i    (y_s[k]),
      .z_i    (z_s[k]),
      .side_o (side_s[k+1]),
      .x_o    (x_s[k+1]),
      .y_o    (y_s[k+1]),
      .z_o    (z_s[k+1])
    );
  end

  cmpt_detect #(
    .XW          (XW),
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_detect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .side_i          (side_s[NS]),
    .x_i             (x_s[NS]),
    .z_i             (z_s[NS]),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

// ===== hw/rtl/cmpt_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation cell with its pipeline register.
module cmpt_cordic_cell import cmpt_pkg::*; #(
  parameter int XW = 28,
  parameter int K  = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cmpt_side_t           side_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output cmpt_side_t           side_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  cmpt_side_t           side_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic signed [ZW-1:0] z_d, z_q;

  always_comb begin
    if (!y_i[XW-1]) begin
      x_d = x_i + (y_i >>> K);
      y_d = y_i - (x_i >>> K);
      z_d = z_i + ATAN_TAB[K];
    end else begin
      x_d = x_i - (y_i >>> K);
      y_d = y_i + (x_i >>> K);
      z_d = z_i - ATAN_TAB[K];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else if (en_i) begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign side_o = side_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== hw/rtl/cmpt_detect.sv =====
// Gain correction, rounding, threshold compare and first-crossing tracking.
module cmpt_detect import cmpt_pkg::*; #(
  parameter int XW          = 28,
  parameter int MAX_SAMPLES = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  cmpt_side_t           side_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [ZW-1:0] z_i,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i,
  output logic                 m_axis_tvalid_o,
  output logic [55:0]          m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  localparam int PW  = XW - 1 + GAIN_W;
  localparam int MW  = (PW - MAG_SHIFT + 1 > 17) ? (PW - MAG_SHIFT + 1) : 17;
  localparam int CAP = (MAX_SAMPLES - 1 > 65535) ? 65535 : (MAX_SAMPLES - 1);
  localparam int CW  = (CAP > 1) ? $clog2(CAP + 1) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAP);

  // multiply stage
  cmpt_side_t    side_a_q;
  logic [PW-1:0] prod_q;
  logic [15:0]   ph_a_q;
  logic [XW-2:0] x_pos;
  logic [ZW-1:0] z_rnd;

  // round stage
  cmpt_side_t    side_b_q;
  logic [15:0]   mag_b_q, mag_b_d, ph_b_q;
  logic [PW:0]   sum;
  logic [MW-1:0] mag_ext;

  // detect stage
  logic          vld_q, last_q;
  logic [15:0]   mag_q, ph_q, hit_q;
  logic          above_q, first_q, found_out_q;
  logic [15:0]   thr_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic          found_q;
  logic          above, first;

  assign x_pos = x_i[XW-1] ? '0 : x_i[XW-2:0];
  assign z_rnd = z_i + ZW'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_a_q <= '0;
      side_b_q <= '0;
    end else if (en_i) begin
      side_a_q <= side_i;
      side_b_q <= side_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= PW'(x_pos) * PW'(GAIN_Q30);
      ph_a_q  <= z_rnd[31:16];
      mag_b_q <= mag_b_d;
      ph_b_q  <= side_a_q.zero ? '0 : ph_a_q;
    end
  end

  always_comb begin
    sum     = {1'b0, prod_q} + (PW+1)'(64'd1 << (MAG_SHIFT - 1));
    mag_ext = MW'(sum[PW:MAG_SHIFT]);
    if (side_a_q.zero) begin
      mag_b_d = '0;
    end else if (|mag_ext[MW-1:16]) begin
      mag_b_d = 16'hFFFF;
    end else begin
      mag_b_d = mag_ext[15:0];
    end
  end

  assign above = mag_b_q > thr_q;
  assign first = above && !found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RST;
      vld_q   <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (en_i) begin
        vld_q <= side_b_q.vld;
        if (side_b_q.vld) begin
          if (side_b_q.last) begin
            cnt_q   <= '0;
            idx_q   <= '0;
            found_q <= 1'b0;
          end else begin
            if (cnt_q < CAP_C) begin
              cnt_q <= cnt_q + CW'(1);
            end
            if (first) begin
              idx_q   <= cnt_q;
              found_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q       <= mag_b_q;
      ph_q        <= ph_b_q;
      above_q     <= above;
      first_q     <= first;
      found_out_q <= found_q | above;
      hit_q       <= first ? 16'(cnt_q) : 16'(idx_q);
      last_q      <= side_b_q.last;
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {5'd0, hit_q, found_out_q, first_q, above_q, ph_q, mag_q};

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the CORDIC magnitude/phase threshold detector: scoreboarded stream traffic.
module testbench;
  import cmpt_pkg::*;

  localparam int STAGES      = 16;
  localparam int TAIL_CYCLES = 24;
  localparam int CYCLE_LIMIT = 1000000;

  localparam longint ATAN_Q31 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct {
    logic [15:0] mag;
    logic [15:0] phase;
    logic        above;
    logic        first_hit;
    logic        found;
    logic [15:0] hit_index;
    logic        eob;
  } det_result_t;

  class detect_scoreboard;
    logic [15:0] threshold;
    logic [15:0] index_count;
    bit          hit_seen;
    logic [15:0] hit_at;
    det_result_t expected_results[$];
    int          mismatches;

    function new();
      threshold   = THRESHOLD_RST;
      index_count = '0;
      hit_seen    = 1'b0;
      hit_at      = '0;
      mismatches  = 0;
    endfunction

    function void note_sample(logic signed [15:0] si, logic signed [15:0] sq, logic is_last);
      longint x, y, z, dx, dy, ph;
      longint unsigned rounded;
      det_result_t r;
      x = longint'(si);
      y = longint'(sq);
      z = 0;
      r.mag = '0;
      r.phase = '0;
      if (x != 0 || y != 0) begin
        if (x < 0) begin
          x = -x;
          y = -y;
          z = 64'sd2147483648;
        end
        x = x * 256;
        y = y * 256;
        for (int k = 0; k < STAGES; k++) begin
          dx = y >>> k;
          dy = x >>> k;
          if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_Q31[k];
          end else begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_Q31[k];
          end
        end
        if (x < 0) x = 0;
        rounded = (longint'(unsigned'(x)) * 64'd652032874 + (64'd1 << 37)) >> 38;
        r.mag = (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
        ph = (z + 32768) >>> 16;
        r.phase = ph[15:0];
      end
      r.above     = r.mag > threshold;
      r.first_hit = r.above && !hit_seen;
      if (r.first_hit) begin
        hit_seen = 1'b1;
        hit_at   = index_count;
      end
      r.found     = hit_seen;
      r.hit_index = hit_seen ? hit_at : 16'd0;
      r.eob       = is_last;
      expected_results.insert(expected_results.size(), r);
      if (is_last) begin
        index_count = '0;
        hit_seen    = 1'b0;
        hit_at      = '0;
      end else if (index_count != 16'hFFFF) begin
        index_count++;
      end
    endfunction

    function void check_result(logic [55:0] d, logic tl);
      det_result_t e, a;
      a.mag       = d[15:0];
      a.phase     = d[31:16];
      a.above     = d[32];
      a.first_hit = d[33];
      a.found     = d[34];
      a.hit_index = d[50:35];
      a.eob       = tl;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: mag %0d ph %0d idx %0d", a.mag, a.phase, a.hit_index);
        return;
      end
      e = expected_results.pop_front();
      if (a.mag !== e.mag || a.phase !== e.phase || a.above !== e.above ||
          a.first_hit !== e.first_hit || a.found !== e.found ||
          a.hit_index !== e.hit_index || a.eob !== e.eob || d[55:51] !== 5'd0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: mag %0d ph %0d above %0b first %0b found %0b idx %0d eob %0b",
                   e.mag, $signed(e.phase), e.above, e.first_hit, e.found, e.hit_index, e.eob);
          $display("         got: mag %0d ph %0d above %0b first %0b found %0b idx %0d eob %0b pad %h",
                   a.mag, $signed(a.phase), a.above, a.first_hit, a.found, a.hit_index, a.eob,
                   d[55:51]);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  detect_scoreboard sb = new();

  complex_mag_phase_threshold_detect_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_ready) sb.check_result(m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_sample(logic signed [15:0] si, logic signed [15:0] sq, logic is_last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {sq, si};
    s_last  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(si, sq, is_last);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_threshold(logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.threshold = v;
  endtask

  task automatic run_random(int n, int pause_at);
    int sent, len, ai, bi;
    logic signed [15:0] si, sq;
    logic is_last;
    sent = 0;
    while (sent < n) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 20);
      for (int j = 0; j < len && sent < n; j++) begin
        is_last = (j == len - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            si = 16'($urandom);
            sq = 16'($urandom);
          end
          4, 5: begin
            si = 16'($urandom_range(0, 511));
            sq = 16'($urandom_range(0, 511));
            si = si - 16'sd256;
            sq = sq - 16'sd256;
          end
          default: begin
            // close to the threshold
            if (sb.threshold > 32000) begin
              ai = (int'(sb.threshold) * 23170) >>> 15;
              bi = ai;
            end else begin
              ai = int'(sb.threshold);
              bi = 0;
            end
            ai = ai + $urandom_range(0, 6) - 3;
            bi = bi + $urandom_range(0, 6) - 3;
            if (ai > 32767) ai = 32767;
            if (ai < 0) ai = 0;
            if (bi > 32767) bi = 32767;
            si = 16'(ai);
            sq = 16'(bi);
            if ($urandom_range(0, 1)) {si, sq} = {sq, si};
            if ($urandom_range(0, 1)) si = -si;
            if ($urandom_range(0, 1)) sq = -sq;
          end
        endcase
        push_sample(si, sq, is_last);
        sent++;
        if (sent == pause_at) drain();
      end
    end
    drain();
  endtask

  initial begin
    logic signed [15:0] si, sq;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    set_threshold(16'd32768);
    push_sample(16'sd0, 16'sd0, 1'b0);
    push_sample(16'sd32767, 16'sd0, 1'b0);
    push_sample(-16'sd32768, 16'sd0, 1'b0);
    push_sample(-16'sd1, 16'sd0, 1'b0);
    push_sample(16'sd1, 16'sd0, 1'b0);
    push_sample(16'sd0, 16'sd32767, 1'b0);
    push_sample(16'sd0, -16'sd32768, 1'b0);
    push_sample(16'sd32767, 16'sd32767, 1'b0);
    push_sample(-16'sd32768, -16'sd32768, 1'b0);
    push_sample(-16'sd32768, 16'sd32767, 1'b0);
    push_sample(16'sd32767, -16'sd32768, 1'b0);
    push_sample(16'sd1, 16'sd1, 1'b0);
    push_sample(-16'sd1, -16'sd1, 1'b0);
    push_sample(16'sd23170, 16'sd23170, 1'b1);
    push_sample(16'sd0, 16'sd0, 1'b1);
    push_sample(-16'sd32768, -16'sd32768, 1'b0);
    push_sample(16'sd0, 16'sd0, 1'b0);
    push_sample(-16'sd32768, -16'sd32768, 1'b1);
    push_sample(-16'sd32768, 16'sd1, 1'b1);
    push_sample(-16'sd32768, -16'sd1, 1'b0);
    push_sample(16'sd0, 16'sd1, 1'b1);
    drain();

    set_threshold(16'd0);
    run_random(220, -1);

    idle_pct = 46;
    set_threshold(16'd46341);
    run_random(220, -1);

    idle_pct  = 0;
    stall_pct = 46;
    set_threshold(16'($urandom_range(0, 46341)));
    run_random(220, 110);

    idle_pct  = 15;
    stall_pct = 15;
    set_threshold(16'($urandom_range(0, 46341)));
    run_random(220, -1);

    idle_pct  = 0;
    stall_pct = 0;
    set_threshold(16'($urandom_range(0, 46341)));
    run_random(220, -1);

    // longer quiet buffer with a crossing near its end
    set_threshold(16'd1000);
    for (int n = 0; n < 60; n++) begin
      si = 16'($urandom_range(0, 400));
      sq = 16'($urandom_range(0, 400));
      push_sample(si - 16'sd200, sq - 16'sd200, 1'b0);
    end
    push_sample(16'sd20000, 16'sd0, 1'b0);
    push_sample(16'sd5, 16'sd5, 1'b0);
    push_sample(16'sd30000, -16'sd30000, 1'b1);
    push_sample(16'sd20000, 16'sd0, 1'b1);
    drain();

    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
